### rtl/scanline_polygon_span_fill_unit_defines.svh
// Assertion macros for the scanline polygon span fill unit.
`ifndef SCANLINE_POLYGON_SPAN_FILL_UNIT_DEFINES_SVH
`define SCANLINE_POLYGON_SPAN_FILL_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SPF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spfill assertion failed");

// Next-cycle implication, disabled during reset.
`define SPF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spfill assertion failed");

`endif

### rtl/spfill_pkg.sv
// Shared constants and types for the scanline polygon span fill unit.
package spfill_pkg;

  localparam int DEF_MAX_VERTICES = 16;
  localparam int DEF_LINES        = 600;
  localparam int DEF_FRAC_BITS    = 14;

  localparam int COORD_W   = 10;
  localparam int MIN_VERTS = 3;
  localparam int SPAN_CAP  = 4;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_VERTEX = 2'd1;
  localparam logic [1:0] REQ_LINE   = 2'd2;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_FETCH  = 8'b0000_0010,
    ST_EDGE   = 8'b0000_0100,
    ST_DIV    = 8'b0000_1000,
    ST_RETIRE = 8'b0001_0000,
    ST_SORT   = 8'b0010_0000,
    ST_STEP   = 8'b0100_0000,
    ST_EMIT   = 8'b1000_0000
  } state_t;

  // Divider handshake between sequencer and divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### rtl/scanline_polygon_span_fill_unit.sv
// Scanline polygon span fill unit: vertex store, active edge table and span emitter.
//
// Requests arrive on the s_ side: clear (restart at line 0), add vertex, or next
// scanline. Clear and add-vertex give no result. A scanline request walks the
// stored vertices one memory read per vertex, activating edges whose lower end
// lies on the line; every activated edge runs the shared serial divider for its
// inverse slope. Edges that reach their top are retired, the table is sorted by
// x in MAX_VERTICES odd-even passes, x is stepped, and the spans of edge pairs
// 0/1, 4/5, 8/9 and 12/13 go out one per cycle on the m_ side while m_tready
// allows (at most four; an empty line gives one result with span_valid low). The
// time for a scanline is dominated by the vertex walk, the divider and the sort
// passes. Only one request is worked on at a time; s_tready is high only while
// idle with the output register empty or being drained in the same cycle. Once
// LINES lines are done, a scanline request returns a single result with
// done_res set.
`include "scanline_polygon_span_fill_unit_defines.svh"

module scanline_polygon_span_fill_unit import spfill_pkg::*; #(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int LINES        = DEF_LINES,
  parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // vertex_x[9:0], vertex_y[19:10], zero pad
  input  logic [1:0]            s_tuser,   // req_type[1:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // line_y[9:0], span_start[19:10], span_end[29:20]
  output logic [1:0]            m_tuser,   // span_valid[0], done_res[1]
  output logic                  m_tlast
);

  localparam int VCW = $clog2(MAX_VERTICES + 1);  // counts
  localparam int VAW = $clog2(MAX_VERTICES);      // addresses
  localparam int LW  = $clog2(LINES + 1);
  localparam int XW  = FRAC_BITS + 12;            // edge x, signed
  localparam int SW  = FRAC_BITS + 11;            // slope, signed
  localparam int QW  = COORD_W + FRAC_BITS;       // divider width
  localparam int VW  = 2 * COORD_W;
  localparam logic signed [XW:0] XLIM  = (XW + 1)'(64'sd1 <<< (FRAC_BITS + 10));
  localparam logic signed [XW:0] XNLIM = -XLIM;

  state_t state;

  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  // request handshake
  logic s_acc;
  assign s_tready = (state == ST_IDLE) && out_free;
  assign s_acc    = s_tvalid && s_tready;

  logic [COORD_W-1:0] in_x, in_y;
  assign in_x = s_tdata[COORD_W-1:0];
  assign in_y = s_tdata[VW-1:COORD_W];

  // vertex memory
  logic [VW-1:0]      vmem [MAX_VERTICES];
  logic [VW-1:0]      rd_data;
  logic [VAW-1:0]     rd_addr;
  logic [VCW-1:0]     vcount;
  logic [VCW-1:0]     rd_idx;
  logic [COORD_W-1:0] prev_x, prev_y;

  assign rd_addr = (rd_idx == vcount) ? '0 : rd_idx[VAW-1:0];

  always_ff @(posedge clk) begin
    if (s_acc && s_tuser == REQ_VERTEX && vcount < VCW'(MAX_VERTICES))
      vmem[vcount[VAW-1:0]] <= {in_y, in_x};
    rd_data <= vmem[rd_addr];
  end

  // edge candidate from previous and current vertex
  logic [COORD_W-1:0] cur_x, cur_y, lo_x, lo_y, hi_x, hi_y, dx_mag;
  logic               vswap, dx_neg, edge_act;
  logic [VCW-1:0]     acount;
  logic [LW-1:0]      line;

  assign cur_x  = rd_data[COORD_W-1:0];
  assign cur_y  = rd_data[VW-1:COORD_W];
  assign vswap  = prev_y > cur_y;
  assign lo_x   = vswap ? cur_x : prev_x;
  assign lo_y   = vswap ? cur_y : prev_y;
  assign hi_x   = vswap ? prev_x : cur_x;
  assign hi_y   = vswap ? prev_y : cur_y;
  assign dx_neg = hi_x < lo_x;
  assign dx_mag = dx_neg ? lo_x - hi_x : hi_x - lo_x;
  assign edge_act = (rd_idx != '0) && (prev_y != cur_y) &&
                    ((COORD_W + 1)'(lo_y) == (COORD_W + 1)'(line)) &&
                    (acount < VCW'(MAX_VERTICES));

  // shared divider
  logic          div_start;
  div_stat_t     div_stat;
  logic [QW-1:0] div_q;

  assign div_start = (state == ST_EDGE) && edge_act;

  spfill_div #(.NW(QW), .DW(COORD_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({dx_mag, FRAC_BITS'(0)}),
    .divisor  (hi_y - lo_y),
    .stat     (div_stat),
    .quotient (div_q)
  );

  logic [COORD_W-1:0] e_ymax, e_x0;
  logic               e_neg;
  logic signed [SW-1:0] div_slope;
  assign div_slope = e_neg ? -$signed(SW'(div_q)) : $signed(SW'(div_q));

  // active edge table cells
  logic [COORD_W-1:0]   c_ymax  [MAX_VERTICES];
  logic signed [XW-1:0] c_x     [MAX_VERTICES];
  logic signed [SW-1:0] c_slope [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] c_val;

  // retire mask and its population
  logic [MAX_VERTICES-1:0] ret_mask;
  logic [VCW-1:0]          ret_cnt;
  always_comb begin
    ret_cnt = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      ret_mask[i] = c_val[i] && ((COORD_W + 1)'(c_ymax[i]) == (COORD_W + 1)'(line));
      ret_cnt     = ret_cnt + VCW'(ret_mask[i]);
    end
  end

  // one odd-even transposition pass; invalid cells sink to the end
  logic [VAW-1:0]          sort_cnt;
  logic [COORD_W-1:0]      n_ymax  [MAX_VERTICES];
  logic signed [XW-1:0]    n_x     [MAX_VERTICES];
  logic signed [SW-1:0]    n_slope [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] n_val;
  always_comb begin
    logic sw;
    n_ymax  = c_ymax;
    n_x     = c_x;
    n_slope = c_slope;
    n_val   = c_val;
    for (int i = 0; i < MAX_VERTICES - 1; i++) begin
      sw = (i[0] == sort_cnt[0]) &&
           ((!c_val[i] && c_val[i+1]) ||
            (c_val[i] && c_val[i+1] && (c_x[i] > c_x[i+1])));
      if (sw) begin
        n_ymax[i]  = c_ymax[i+1];  n_ymax[i+1]  = c_ymax[i];
        n_x[i]     = c_x[i+1];     n_x[i+1]     = c_x[i];
        n_slope[i] = c_slope[i+1]; n_slope[i+1] = c_slope[i];
        n_val[i]   = c_val[i+1];   n_val[i+1]   = c_val[i];
      end
    end
  end

  // x step with saturation
  logic signed [XW-1:0] step_x [MAX_VERTICES];
  always_comb begin
    logic signed [XW:0] sum;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      sum = (XW + 1)'(c_x[i]) + (XW + 1)'(c_slope[i]);
      if (sum > XLIM)       step_x[i] = XW'(XLIM);
      else if (sum < XNLIM) step_x[i] = XW'(XNLIM);
      else                  step_x[i] = XW'(sum);
    end
  end

  function automatic logic [COORD_W-1:0] to_pixel(input logic signed [XW-1:0] v);
    logic [XW-FRAC_BITS-1:0] p;
    p = v[XW-1:FRAC_BITS];
    if (v < 0)                     return '0;
    else if (p > (XW - FRAC_BITS)'(1023)) return COORD_W'(1023);
    else                           return p[COORD_W-1:0];
  endfunction

  // span candidates at pairs 0/1, 4/5, 8/9, 12/13
  logic [COORD_W-1:0] sp_s_n [SPAN_CAP];
  logic [COORD_W-1:0] sp_e_n [SPAN_CAP];
  logic [2:0]         nsp_n;
  always_comb begin
    int a;
    nsp_n = '0;
    for (int p = 0; p < SPAN_CAP; p++) begin
      a = (4 * p + 1 < MAX_VERTICES) ? 4 * p : 0;
      sp_s_n[p] = to_pixel(c_x[a]);
      sp_e_n[p] = to_pixel(c_x[a + 1]);
      if (4 * p + 1 < MAX_VERTICES && 32'(acount) > 4 * p + 1 &&
          vcount >= VCW'(MIN_VERTS))
        nsp_n = nsp_n + 3'd1;
    end
  end

  logic [COORD_W-1:0] sp_s [SPAN_CAP];
  logic [COORD_W-1:0] sp_e [SPAN_CAP];
  logic [2:0]         nsp;
  logic [1:0]         ecnt;
  logic [COORD_W-1:0] emit_line;

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      vcount   <= '0;
      acount   <= '0;
      line     <= '0;
      rd_idx   <= '0;
      sort_cnt <= '0;
      ecnt     <= '0;
      c_val    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_acc) begin
            case (s_tuser)
              REQ_CLEAR: begin
                vcount <= '0;
                acount <= '0;
                line   <= '0;
                c_val  <= '0;
              end
              REQ_VERTEX: begin
                if (vcount < VCW'(MAX_VERTICES)) vcount <= vcount + VCW'(1);
              end
              REQ_LINE: begin
                if (32'(line) >= LINES) begin
                  m_tvalid <= 1'b1;
                end else begin
                  rd_idx <= '0;
                  state  <= (vcount >= VCW'(MIN_VERTS)) ? ST_FETCH : ST_RETIRE;
                end
              end
              default: ;
            endcase
          end
        end
        ST_FETCH: state <= ST_EDGE;
        ST_EDGE: begin
          if (edge_act) begin
            state <= ST_DIV;
          end else if (rd_idx == vcount) begin
            state <= ST_RETIRE;
          end else begin
            rd_idx <= rd_idx + VCW'(1);
            state  <= ST_FETCH;
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            c_val[acount[VAW-1:0]] <= 1'b1;
            acount <= acount + VCW'(1);
            if (rd_idx == vcount) begin
              state <= ST_RETIRE;
            end else begin
              rd_idx <= rd_idx + VCW'(1);
              state  <= ST_FETCH;
            end
          end
        end
        ST_RETIRE: begin
          c_val    <= c_val & ~ret_mask;
          acount   <= acount - ret_cnt;
          sort_cnt <= '0;
          state    <= ST_SORT;
        end
        ST_SORT: begin
          c_val    <= n_val;
          sort_cnt <= sort_cnt + VAW'(1);
          if (sort_cnt == VAW'(MAX_VERTICES - 1)) state <= ST_STEP;
        end
        ST_STEP: begin
          line  <= line + LW'(1);
          ecnt  <= '0;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            if (nsp == '0 || 3'(ecnt) == nsp - 3'd1) state <= ST_IDLE;
            else ecnt <= ecnt + 2'd1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // edge payload and span registers
  always_ff @(posedge clk) begin
    case (state)
      ST_EDGE: begin
        prev_x <= cur_x;
        prev_y <= cur_y;
        e_ymax <= hi_y;
        e_x0   <= lo_x;
        e_neg  <= dx_neg;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          c_ymax[acount[VAW-1:0]]  <= e_ymax;
          c_x[acount[VAW-1:0]]     <= $signed({2'b00, e_x0, FRAC_BITS'(0)});
          c_slope[acount[VAW-1:0]] <= div_slope;
        end
      end
      ST_SORT: begin
        c_ymax  <= n_ymax;
        c_x     <= n_x;
        c_slope <= n_slope;
      end
      ST_STEP: begin
        c_x       <= step_x;
        sp_s      <= sp_s_n;
        sp_e      <= sp_e_n;
        nsp       <= nsp_n;
        emit_line <= COORD_W'(line);
      end
      default: ;
    endcase
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_acc && s_tuser == REQ_LINE) begin
      m_tdata <= '0;
      m_tuser <= 2'b10;
      m_tlast <= 1'b1;
    end else if (state == ST_EMIT && out_free) begin
      if (nsp == '0) begin
        m_tdata <= {(OUT_DATA_W - COORD_W)'(0), emit_line};
        m_tuser <= 2'b00;
        m_tlast <= 1'b1;
      end else begin
        m_tdata <= {2'b00, sp_e[ecnt], sp_s[ecnt], emit_line};
        m_tuser <= 2'b01;
        m_tlast <= (3'(ecnt) == nsp - 3'd1);
      end
    end
  end

  // checks
  `SPF_ASSERT_NOW(a_ready_free, clk, rst, s_tready, !m_tvalid || m_tready)
  `SPF_ASSERT_NEXT(a_done_result, clk, rst,
    s_acc && s_tuser == REQ_LINE && 32'(line) >= LINES,
    m_tvalid && m_tuser[1] && m_tlast)
  `SPF_ASSERT_NOW(a_table_bound, clk, rst, 1'b1, acount <= VCW'(MAX_VERTICES))
  `SPF_ASSERT_NOW(a_done_last, clk, rst, m_tvalid && m_tuser[1], m_tlast && !m_tuser[0])

endmodule

### rtl/spfill_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module spfill_div import spfill_pkg::*; #(
  parameter int NW = 24,
  parameter int DW = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output div_stat_t     stat,
  output logic [NW-1:0] quotient
);

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [NW-1:0] q;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic [DW:0]   trial;
  logic          ge;

  assign trial = {rem, q[NW-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      q   <= dividend;
    end else if (busy) begin
      rem <= ge ? DW'(trial - {1'b0, dvs}) : DW'(trial);
      q   <= {q[NW-2:0], ge};
    end
  end

  assign quotient  = q;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule
